FILE: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and the phase table of the I2C byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] CMD_IDLE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_WRITE   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_RELEASE = 3'd6;

  localparam logic LINE_SCL = 1'b0;
  localparam logic LINE_SDA = 1'b1;

  localparam logic [15:0] PHASE_LEN_RST = 16'd10;
  localparam logic [4:0]  WR_ACK_PHASE  = 5'd25;
  localparam logic [4:0]  RD_BIT_FIRST  = 5'd2;
  localparam logic [4:0]  RD_BIT_END    = 5'd18;

  typedef struct packed {
    logic valid;
    logic line;
    logic level;
  } phase_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
    logic       rejected;
  } res_t;

  function automatic phase_t mk_phase(input logic line, input logic level);
    phase_t ph;
    ph.valid = 1'b1;
    ph.line  = line;
    ph.level = level;
    return ph;
  endfunction

  // line and level driven in phase p of command cmd; valid low past the end
  function automatic phase_t phase_code(input logic [2:0] cmd, input logic [4:0] p,
                                        input logic [7:0] sreg, input logic ackh);
    phase_t ph;
    ph = '0;
    case (cmd)
      CMD_START: begin
        if (p == 5'd0) ph = mk_phase(LINE_SDA, 1'b0);
        else if (p == 5'd1) ph = mk_phase(LINE_SCL, 1'b0);
      end
      CMD_RESTART: begin
        if (p == 5'd0) ph = mk_phase(LINE_SDA, 1'b1);
        else if (p == 5'd1) ph = mk_phase(LINE_SCL, 1'b1);
        else if (p == 5'd2) ph = mk_phase(LINE_SDA, 1'b0);
        else if (p == 5'd3) ph = mk_phase(LINE_SCL, 1'b0);
      end
      CMD_STOP: begin
        if (p == 5'd0) ph = mk_phase(LINE_SDA, 1'b0);
        else if (p == 5'd1) ph = mk_phase(LINE_SCL, 1'b1);
        else if (p == 5'd2) ph = mk_phase(LINE_SDA, 1'b1);
      end
      CMD_WRITE: begin
        for (int i = 0; i < 8; i++) begin
          if (p == 5'(3 * i)) ph = mk_phase(LINE_SDA, sreg[3'(7 - i)]);
          if (p == 5'(3 * i + 1)) ph = mk_phase(LINE_SCL, 1'b1);
          if (p == 5'(3 * i + 2)) ph = mk_phase(LINE_SCL, 1'b0);
        end
        if (p == 5'd24) ph = mk_phase(LINE_SDA, 1'b1);
        else if (p == 5'd25) ph = mk_phase(LINE_SCL, 1'b1);
        else if (p == 5'd26) ph = mk_phase(LINE_SCL, 1'b0);
        else if (p == 5'd27) ph = mk_phase(LINE_SDA, 1'b0);
      end
      CMD_READ: begin
        if (p == 5'd0) ph = mk_phase(LINE_SCL, 1'b0);
        else if (p == 5'd1) ph = mk_phase(LINE_SDA, 1'b1);
        else if (p < RD_BIT_END) ph = mk_phase(LINE_SCL, ~p[0]);
        else if (p == 5'd18) ph = mk_phase(LINE_SDA, ~ackh);
        else if (p == 5'd19) ph = mk_phase(LINE_SCL, 1'b1);
        else if (p == 5'd20) ph = mk_phase(LINE_SCL, 1'b0);
        else if (p == 5'd21) ph = mk_phase(LINE_SDA, 1'b0);
      end
      CMD_RELEASE: begin
        if (p == 5'd0) ph = mk_phase(LINE_SCL, 1'b1);
        else if (p == 5'd1) ph = mk_phase(LINE_SDA, 1'b1);
      end
      default: ph = '0;
    endcase
    return ph;
  endfunction

endpackage

FILE: hw/rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// Request and result channel interfaces of the I2C byte engine.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic       sda_in;

  modport source (output valid, kind, tx_byte, ack_to_send, sda_in, input ready);
  modport sink   (input valid, kind, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack;
  logic       rejected;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
                  rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
                  rejected, output ready);
endinterface

FILE: hw/rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Phase sequencer: command state, phase timer, shift register and flags.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             accept,
  input  logic [2:0]       kind,
  input  logic [7:0]       tx_byte,
  input  logic             ack_to_send,
  input  logic             sda_in,
  output i2cm_pkg::res_t   res
);

  logic [15:0] plen_r;
  logic [2:0]  cmd_r,  cmd_nxt;
  logic [4:0]  pidx_r, pidx_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  logic [7:0]  sreg_r, sreg_nxt;
  logic        scl_r,  scl_nxt;
  logic        sda_r,  sda_nxt;
  logic [7:0]  rxb_r,  rxb_nxt;
  logic        nack_r, nack_nxt;
  logic        ackh_r, ackh_nxt;

  logic [15:0]      len;
  logic             is_cmd;
  logic             done;
  logic             rej;
  i2cm_pkg::phase_t ph_step;
  i2cm_pkg::phase_t ph_first;

  assign len    = (plen_r == 16'd0) ? 16'd1 : plen_r;
  assign is_cmd = kind inside {[i2cm_pkg::CMD_START:i2cm_pkg::CMD_RELEASE]};

  assign ph_step = i2cm_pkg::phase_code(cmd_r, 5'(pidx_r + 5'd1), sreg_r, ackh_r);

  always_comb begin
    cmd_nxt  = cmd_r;
    pidx_nxt = pidx_r;
    tcnt_nxt = tcnt_r;
    sreg_nxt = sreg_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    rxb_nxt  = rxb_r;
    nack_nxt = nack_r;
    ackh_nxt = ackh_r;
    done     = 1'b0;
    rej      = 1'b0;

    if (cmd_r != i2cm_pkg::CMD_IDLE) begin
      if (tcnt_r >= len) begin
        if (!ph_step.valid) begin
          if (cmd_r == i2cm_pkg::CMD_READ) rxb_nxt = sreg_r;
          cmd_nxt  = i2cm_pkg::CMD_IDLE;
          pidx_nxt = '0;
          tcnt_nxt = '0;
          done     = 1'b1;
        end else begin
          pidx_nxt = 5'(pidx_r + 5'd1);
          tcnt_nxt = '0;
          if (ph_step.line == i2cm_pkg::LINE_SCL) scl_nxt = ph_step.level;
          else sda_nxt = ph_step.level;
        end
      end
      if (cmd_nxt != i2cm_pkg::CMD_IDLE) begin
        tcnt_nxt = 16'(tcnt_nxt + 16'd1);
        rej      = is_cmd;
      end
    end

    ph_first = i2cm_pkg::phase_code(kind, 5'd0, tx_byte, ack_to_send);
    if (cmd_nxt == i2cm_pkg::CMD_IDLE && is_cmd) begin
      cmd_nxt  = kind;
      pidx_nxt = '0;
      tcnt_nxt = 16'd1;
      sreg_nxt = (kind == i2cm_pkg::CMD_WRITE) ? tx_byte : 8'd0;
      ackh_nxt = ack_to_send;
      if (ph_first.line == i2cm_pkg::LINE_SCL) scl_nxt = ph_first.level;
      else sda_nxt = ph_first.level;
    end

    if (cmd_nxt != i2cm_pkg::CMD_IDLE && tcnt_nxt == len) begin
      if (cmd_nxt == i2cm_pkg::CMD_WRITE && pidx_nxt == i2cm_pkg::WR_ACK_PHASE) begin
        nack_nxt = sda_in;
      end else if (cmd_nxt == i2cm_pkg::CMD_READ && pidx_nxt >= i2cm_pkg::RD_BIT_FIRST &&
                   pidx_nxt < i2cm_pkg::RD_BIT_END && !pidx_nxt[0]) begin
        sreg_nxt = {sreg_nxt[6:0], sda_in};
      end
    end

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (cmd_nxt != i2cm_pkg::CMD_IDLE);
    res.done_res = done;
    res.rx_byte  = rxb_nxt;
    res.nack     = nack_nxt;
    res.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= i2cm_pkg::PHASE_LEN_RST;
      cmd_r  <= i2cm_pkg::CMD_IDLE;
      pidx_r <= '0;
      tcnt_r <= '0;
      sreg_r <= '0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
      rxb_r  <= '0;
      nack_r <= 1'b0;
      ackh_r <= 1'b0;
    end else begin
      if (cfg_wr_en) plen_r <= cfg_wr_data;
      if (accept) begin
        cmd_r  <= cmd_nxt;
        pidx_r <= pidx_nxt;
        tcnt_r <= tcnt_nxt;
        sreg_r <= sreg_nxt;
        scl_r  <= scl_nxt;
        sda_r  <= sda_nxt;
        rxb_r  <= rxb_nxt;
        nack_r <= nack_nxt;
        ackh_r <= ackh_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/i2cm_skid.sv
// ----------------------------------------------------------------------------
// i2cm_skid
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module i2cm_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             push_ready,
  input  i2cm_pkg::res_t   push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output i2cm_pkg::res_t   pop_data
);

  i2cm_pkg::res_t head_r, head_nxt;
  i2cm_pkg::res_t spare_r, spare_nxt;
  logic           head_v_r, head_v_nxt;
  logic           spare_v_r, spare_v_nxt;
  logic           pop;

  assign push_ready = !spare_v_r;
  assign pop_valid  = head_v_r;
  assign pop_data   = head_r;
  assign pop        = head_v_r && pop_ready;

  always_comb begin
    head_nxt    = head_r;
    spare_nxt   = spare_r;
    head_v_nxt  = head_v_r;
    spare_v_nxt = spare_v_r;
    if (head_v_r && !pop) begin
      if (push) begin
        spare_nxt   = push_data;
        spare_v_nxt = 1'b1;
      end
    end else if (spare_v_r) begin
      head_nxt    = spare_r;
      head_v_nxt  = 1'b1;
      spare_v_nxt = push;
      if (push) spare_nxt = push_data;
    end else begin
      head_v_nxt = push;
      if (push) head_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

endmodule

FILE: hw/rtl/i2c_master_byte_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Tick-driven I2C master byte engine with request/result channels.
// ----------------------------------------------------------------------------
// Each request is one time tick and yields exactly one result. A request is
// taken every cycle while the two-entry result buffer has room; its result is
// registered and shows on the result channel once earlier results are taken.
// Throughput is one tick per clock while the buffer has room. The user writes
// phase_length through cfg_wr_en/cfg_wr_data only while idle (not enforced).
module i2c_master_byte_engine_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  i2cm_in_if.sink       in_chan,
  i2cm_out_if.source    out_chan
);

  logic           accept;
  logic           buf_ready;
  i2cm_pkg::res_t res;
  i2cm_pkg::res_t out_res;

  assign in_chan.ready = buf_ready;
  assign accept        = in_chan.valid && buf_ready;

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .kind        (in_chan.kind),
    .tx_byte     (in_chan.tx_byte),
    .ack_to_send (in_chan.ack_to_send),
    .sda_in      (in_chan.sda_in),
    .res         (res)
  );

  i2cm_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_ready (buf_ready),
    .push_data  (res),
    .pop_valid  (out_chan.valid),
    .pop_ready  (out_chan.ready),
    .pop_data   (out_res)
  );

  assign out_chan.scl_out  = out_res.scl_out;
  assign out_chan.sda_out  = out_res.sda_out;
  assign out_chan.busy_res = out_res.busy_res;
  assign out_chan.done_res = out_res.done_res;
  assign out_chan.rx_byte  = out_res.rx_byte;
  assign out_chan.nack     = out_res.nack;
  assign out_chan.rejected = out_res.rejected;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick-driven I2C master byte engine.
// Sends one request per tick, predicts SCL/SDA drive, busy, done, received
// byte, nack and rejected for every tick, and compares each result in order.
// A short directed table is followed by random command streams at several
// phase lengths, with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  localparam logic [2:0] KIND_SPARE  = 3'd7;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         ROW_COUNT   = 15;
  localparam int         PHASE_COUNT = 8;
  localparam int         PHASE_REQS  = 72;
  localparam int         HOLD_CYCLES = 60;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx;
    logic       ack;
    logic       sda;
  } req_t;

  typedef struct packed {
    logic ok;
    logic on_sda;
    logic lvl;
  } drive_t;

  typedef struct packed {
    req_t       rq;
    logic [5:0] n;
    logic       typed;
    res_t       want;
  } row_t;

  // first request of each row, then n-1 plain ticks; typed rows carry the result
  localparam row_t DIRECTED [ROW_COUNT] = '{
    '{'{CMD_IDLE,    8'h00, 1'b0, 1'b1}, 6'd1,  1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{KIND_SPARE,  8'hA5, 1'b1, 1'b0}, 6'd1,  1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{CMD_START,   8'h00, 1'b0, 1'b1}, 6'd1,  1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
    '{'{CMD_STOP,    8'hFF, 1'b1, 1'b1}, 6'd1,  1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{'{CMD_WRITE,   8'hFF, 1'b0, 1'b1}, 6'd28, 1'b1,
      '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0}},
    '{'{CMD_WRITE,   8'h00, 1'b1, 1'b0}, 6'd28, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0}},
    '{'{CMD_READ,    8'h00, 1'b1, 1'b1}, 6'd22, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0}},
    '{'{CMD_READ,    8'h5A, 1'b0, 1'b0}, 6'd22, 1'b0, '0},
    '{'{CMD_RESTART, 8'h00, 1'b0, 1'b1}, 6'd4,  1'b0, '0},
    '{'{CMD_RELEASE, 8'h00, 1'b0, 1'b1}, 6'd2,  1'b0, '0},
    '{'{CMD_STOP,    8'h00, 1'b0, 1'b1}, 6'd3,  1'b0, '0},
    '{'{CMD_START,   8'h00, 1'b0, 1'b1}, 6'd1,  1'b0, '0},
    '{'{KIND_SPARE,  8'hFF, 1'b1, 1'b1}, 6'd1,  1'b0, '0},
    '{'{CMD_RELEASE, 8'h00, 1'b0, 1'b0}, 6'd2,  1'b0, '0},
    '{'{CMD_IDLE,    8'h00, 1'b0, 1'b1}, 6'd1,  1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0}}
  };

  localparam logic [15:0] RAND_LEN [PHASE_COUNT] = '{
    16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd2, 16'd4, PHASE_LEN_RST
  };
  localparam idle_mode_t RAND_MODE [PHASE_COUNT] = '{
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV, IDLE_SEND, IDLE_BOTH
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  i2cm_in_if  in_if();
  i2cm_out_if out_if();

  i2c_master_byte_engine_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bus sequencer state as predicted
  logic [15:0] phase_len_q = PHASE_LEN_RST;
  logic [2:0]  seq_cmd     = CMD_IDLE;
  logic [4:0]  seq_phase   = '0;
  logic [15:0] seq_ticks   = '0;
  logic [7:0]  shift_q     = '0;
  logic        scl_q       = 1'b1;
  logic        sda_q       = 1'b1;
  logic [7:0]  rx_q        = '0;
  logic        nack_q      = 1'b0;
  logic        ack_q       = 1'b0;

  res_t        bus_results_due[$];
  res_t        head_res;
  int          snd_idle    = 0;
  int          rcv_stall   = 0;
  int          hold_len    = 0;
  int          quiet_cycles = 0;
  int unsigned errors      = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_rej       = 0;
  int unsigned n_done      = 0;
  int unsigned n_started [8] = '{default: 0};

  function automatic drive_t drive_for(input logic [2:0] c, input int p);
    drive_t d;
    d = '0;
    case (c)
      CMD_START:   if (p < 2) d = '{1'b1, p == 0, 1'b0};
      CMD_RESTART: if (p < 4) d = '{1'b1, p % 2 == 0, p < 2};
      CMD_STOP:    if (p < 3) d = '{1'b1, p != 1, p != 0};
      CMD_RELEASE: if (p < 2) d = '{1'b1, p == 1, 1'b1};
      CMD_WRITE: begin
        if (p < 24) begin
          if (p % 3 == 0) d = '{1'b1, 1'b1, shift_q[7 - p / 3]};
          else d = '{1'b1, 1'b0, p % 3 == 1};
        end else if (p < 28) begin
          d = '{1'b1, p == 24 || p == 27, p < 26};
        end
      end
      CMD_READ: begin
        if (p == 0) d = '{1'b1, 1'b0, 1'b0};
        else if (p == 1) d = '{1'b1, 1'b1, 1'b1};
        else if (p < 18) d = '{1'b1, 1'b0, p % 2 == 0};
        else if (p == 18) d = '{1'b1, 1'b1, !ack_q};
        else if (p < 22) d = '{1'b1, p == 21, p == 19};
      end
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic void put_line(input drive_t d);
    if (d.on_sda) sda_q = d.lvl;
    else scl_q = d.lvl;
  endfunction

  // advances the predicted bus state by one tick and returns that tick's result
  function automatic res_t bus_tick(input req_t r);
    res_t        o;
    drive_t      d;
    logic [15:0] len;
    logic        is_cmd;
    o      = '0;
    len    = (phase_len_q == 16'd0) ? 16'd1 : phase_len_q;
    is_cmd = r.kind >= CMD_START && r.kind <= CMD_RELEASE;
    if (seq_cmd != CMD_IDLE) begin
      if (seq_ticks >= len) begin
        d = drive_for(seq_cmd, int'(seq_phase) + 1);
        if (!d.ok) begin
          if (seq_cmd == CMD_READ) rx_q = shift_q;
          seq_cmd    = CMD_IDLE;
          seq_phase  = '0;
          seq_ticks  = '0;
          o.done_res = 1'b1;
        end else begin
          seq_phase = seq_phase + 5'd1;
          put_line(d);
          seq_ticks = '0;
        end
      end
      if (seq_cmd != CMD_IDLE) begin
        seq_ticks  = seq_ticks + 16'd1;
        o.rejected = is_cmd;
      end
    end
    if (seq_cmd == CMD_IDLE && is_cmd) begin
      seq_cmd   = r.kind;
      seq_phase = '0;
      seq_ticks = 16'd1;
      shift_q   = (r.kind == CMD_WRITE) ? r.tx : 8'h00;
      ack_q     = r.ack;
      put_line(drive_for(seq_cmd, 0));
      n_started[r.kind]++;
    end
    if (seq_cmd != CMD_IDLE && seq_ticks == len) begin
      if (seq_cmd == CMD_WRITE && seq_phase == WR_ACK_PHASE) begin
        nack_q = r.sda;
      end else if (seq_cmd == CMD_READ && seq_phase >= RD_BIT_FIRST &&
                   seq_phase < RD_BIT_END && !seq_phase[0]) begin
        shift_q = {shift_q[6:0], r.sda};
      end
    end
    o.scl_out  = scl_q;
    o.sda_out  = sda_q;
    o.busy_res = seq_cmd != CMD_IDLE;
    o.rx_byte  = rx_q;
    o.nack     = nack_q;
    return o;
  endfunction

  // mostly well-formed: commands while idle, plain ticks while a sequence runs
  function automatic req_t rand_req();
    req_t r;
    r.tx  = 8'($urandom_range(255));
    r.ack = 1'($urandom_range(1));
    r.sda = 1'($urandom_range(1));
    if (seq_cmd == CMD_IDLE) begin
      if ($urandom_range(99) < 65) r.kind = 3'($urandom_range(CMD_RELEASE, CMD_START));
      else r.kind = ($urandom_range(1) != 0) ? KIND_SPARE : CMD_IDLE;
    end else begin
      if ($urandom_range(99) < 5) r.kind = 3'($urandom_range(KIND_SPARE, CMD_START));
      else r.kind = CMD_IDLE;
    end
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_req(input req_t r, input logic typed, input res_t want);
    res_t calc;
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= r.kind;
    in_if.tx_byte     <= r.tx;
    in_if.ack_to_send <= r.ack;
    in_if.sda_in      <= r.sda;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    calc = bus_tick(r);
    bus_results_due.push_back(typed ? want : calc);
    n_ticks++;
    if (calc.rejected) n_rej++;
    if (calc.done_res) n_done++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (bus_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_phase_len(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    phase_len_q = v;
  endtask

  task automatic cmp_field(input string f, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, f, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (bus_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
      end else begin
        head_res = bus_results_due.pop_front();
        cmp_field("scl_out",  head_res.scl_out,  out_if.scl_out);
        cmp_field("sda_out",  head_res.sda_out,  out_if.sda_out);
        cmp_field("busy_res", head_res.busy_res, out_if.busy_res);
        cmp_field("done_res", head_res.done_res, out_if.done_res);
        cmp_field("rx_byte",  head_res.rx_byte,  out_if.rx_byte);
        cmp_field("nack",     head_res.nack,     out_if.nack);
        cmp_field("rejected", head_res.rejected, out_if.rejected);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  initial begin
    req_t       filler;
    idle_mode_t mode;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_if.valid       = 1'b0;
    in_if.kind        = CMD_IDLE;
    in_if.tx_byte     = '0;
    in_if.ack_to_send = 1'b0;
    in_if.sda_in      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero phase length runs as one tick per phase
    set_phase_len(16'd0);
    for (int i = 0; i < ROW_COUNT; i++) begin
      for (int k = 0; k < int'(DIRECTED[i].n); k++) begin
        filler      = DIRECTED[i].rq;
        if (k != 0) filler.kind = CMD_IDLE;
        send_req(filler, DIRECTED[i].typed && k == 0, DIRECTED[i].want);
      end
    end

    // longest phase, then cut short in the middle of it
    wait_drained();
    set_phase_len(16'hFFFF);
    send_req('{CMD_START, 8'h00, 1'b0, 1'b1}, 1'b0, '0);
    repeat (40) send_req('{CMD_IDLE, 8'h3C, 1'b1, 1'b0}, 1'b0, '0);
    wait_drained();
    set_phase_len(16'd3);
    repeat (12) send_req('{CMD_IDLE, 8'hC3, 1'b0, 1'b1}, 1'b0, '0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      set_phase_len(RAND_LEN[p]);
      mode      = RAND_MODE[p];
      snd_idle  = (mode == IDLE_SEND) ? 78 : (mode == IDLE_BOTH) ? 21 : 0;
      rcv_stall = (mode == IDLE_RECV) ? 78 : (mode == IDLE_BOTH) ? 21 : 0;
      if (p == 0) hold_len = HOLD_CYCLES;
      for (int k = 0; k < PHASE_REQS; k++) begin
        if (p == 4 && k == PHASE_REQS / 2) wait_drained();
        send_req(rand_req(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d ticks, %0d results checked, %0d sequences completed, %0d rejected",
             n_ticks, n_checked, n_done, n_rej);
    $display("started: start %0d restart %0d stop %0d write %0d read %0d release %0d",
             n_started[CMD_START], n_started[CMD_RESTART], n_started[CMD_STOP],
             n_started[CMD_WRITE], n_started[CMD_READ], n_started[CMD_RELEASE]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
